// ===== rtl/ccs_pkg.sv =====
// Shared types and constants for the quadrant-3 opcode execute block.
`timescale 1ns / 1ps
package ccs_pkg;
    localparam logic [1:0] KIND_READ  = 2'd0;
    localparam logic [1:0] KIND_WRITE = 2'd1;
    localparam logic [1:0] KIND_DONE  = 2'd2;
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_ILLEGAL = 2'd1;
    localparam logic [1:0] ST_PREFIX  = 2'd2;
    localparam logic       CMD_EXEC   = 1'b0;
    localparam logic       CMD_RESP   = 1'b1;
    localparam logic [15:0] HIGH_PAGE = 16'hFF00;
    localparam logic [3:0] FL_Z = 4'd8;
    localparam logic [3:0] FL_N = 4'd4;
    localparam logic [3:0] FL_H = 4'd2;
    localparam logic [3:0] FL_C = 4'd1;

    typedef struct packed {
        logic        cmd;
        logic [7:0]  opcode;
        logic [15:0] immediate;
        logic [15:0] read_data;
    } t_item;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] bus_address;
        logic [15:0] write_data;
        logic        word_access;
        logic [1:0]  status;
        logic [4:0]  cycle_count;
        logic [15:0] next_pc;
        logic [7:0]  acc_value;
        logic [3:0]  flags_znhc;
        logic        last;
    } t_result;
endpackage

// ===== rtl/ccs_front.sv =====
// Front stage: accept input words into a two-entry queue.
`timescale 1ns / 1ps
module ccs_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  ccs_pkg::t_item i_item,
    output logic           o_valid,
    input  logic           i_take,
    output ccs_pkg::t_item o_item
);
    import ccs_pkg::*;
    t_item r_q [2];
    logic  r_wp, r_rp;
    logic [1:0] r_cnt;
    logic push, pop;

    assign o_stall = (r_cnt == 2'd2);
    assign push    = i_valid && !o_stall;
    assign o_valid = (r_cnt != 2'd0);
    assign pop     = o_valid && i_take;
    assign o_item  = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
        if (push) r_q[r_wp] <= i_item;
    end
endmodule

// ===== rtl/ccs_back.sv =====
// Back stage: execute one queued word, emitting up to two results.
`timescale 1ns / 1ps
module ccs_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_take,
    input  ccs_pkg::t_item   i_item,
    output logic             o_valid,
    input  logic             i_stall,
    output ccs_pkg::t_result o_res
);
    import ccs_pkg::*;
    logic [7:0]  r_a, n_a;
    logic [3:0]  r_f, n_f;
    logic [15:0] r_bc, n_bc, r_de, n_de, r_hl, n_hl, r_sp, n_sp, r_pc, n_pc;
    logic        r_ime, n_ime, r_aw, n_aw;
    logic [7:0]  r_pend, n_pend;
    t_result     r_out0, r_out1, n_r0, n_r1;
    logic        r_v0, r_v1;
    logic [1:0]  n_cnt;

    logic [2:0] y, z, py, pz;
    logic [7:0] b;
    logic cond;
    logic [8:0] sum;
    logic [4:0] hs;
    logic [3:0] fl;
    logic [15:0] spo;
    logic [15:0] pushsp;
    logic [15:0] d;
    logic go;

    // output register frees when the pending results drain
    assign o_valid = r_v0;
    assign o_res   = r_out0;
    assign o_take  = !r_v0 || (!r_v1 && !i_stall);
    assign go      = i_valid && o_take;

    function automatic t_result mk(logic [1:0] k, logic [15:0] ad, logic [15:0] wd,
                                   logic w, logic l);
        t_result r;
        r = '0;
        r.kind = k; r.bus_address = ad; r.write_data = wd; r.word_access = w; r.last = l;
        return r;
    endfunction

    always_comb begin
        y = i_item.opcode[5:3];
        z = i_item.opcode[2:0];
        b = i_item.immediate[7:0];
        py = r_pend[5:3];
        pz = r_pend[2:0];
        d = i_item.read_data;
        case (y[1:0])
            2'd0: cond = !r_f[3];
            2'd1: cond = r_f[3];
            2'd2: cond = !r_f[0];
            default: cond = r_f[0];
        endcase
        spo = r_sp + {{8{b[7]}}, b};
        pushsp = r_sp - 16'd2;
        n_a = r_a; n_f = r_f; n_bc = r_bc; n_de = r_de; n_hl = r_hl; n_sp = r_sp;
        n_pc = r_pc; n_ime = r_ime; n_aw = r_aw; n_pend = r_pend;
        n_r0 = '0; n_r1 = '0; n_cnt = 2'd0;
        sum = '0; hs = '0; fl = '0;
        if (i_item.cmd == CMD_EXEC) begin
            n_aw = 1'b0; n_cnt = 2'd1;
            n_r0 = mk(KIND_DONE, 16'd0, 16'd0, 1'b0, 1'b1);
            n_r0.status = ST_ILLEGAL;
            if (i_item.opcode[7:6] == 2'b11) begin
                n_r0.status = ST_OK;
                case (z)
                    3'd0: begin
                        if (!y[2]) begin
                            if (cond) begin
                                n_r0 = mk(KIND_READ, r_sp, 16'd0, 1'b1, 1'b1);
                                n_aw = 1'b1; n_pend = i_item.opcode;
                            end else begin
                                n_pc = r_pc + 16'd1; n_r0.cycle_count = 5'd8;
                            end
                        end else if (y == 3'd4) begin
                            n_r1 = n_r0; n_r1.cycle_count = 5'd12;
                            n_r0 = mk(KIND_WRITE, HIGH_PAGE + {8'd0, b}, {8'd0, r_a},
                                      1'b0, 1'b0);
                            n_pc = r_pc + 16'd2; n_cnt = 2'd2;
                        end else if (y == 3'd6) begin
                            n_r0 = mk(KIND_READ, HIGH_PAGE + {8'd0, b}, 16'd0, 1'b0, 1'b1);
                            n_aw = 1'b1; n_pend = i_item.opcode;
                        end else begin
                            fl = 4'd0;
                            if ({1'b0, r_sp[3:0]} + {1'b0, b[3:0]} > 5'hF) fl = fl | FL_H;
                            if ({1'b0, r_sp[7:0]} + {1'b0, b} > 9'hFF) fl = fl | FL_C;
                            n_f = fl;
                            if (y == 3'd5) begin
                                n_sp = spo; n_r0.cycle_count = 5'd16;
                            end else begin
                                n_hl = spo; n_r0.cycle_count = 5'd12;
                            end
                            n_pc = r_pc + 16'd2;
                        end
                    end
                    3'd1: begin
                        if (!y[0] || !y[2]) begin
                            n_r0 = mk(KIND_READ, r_sp, 16'd0, 1'b1, 1'b1);
                            n_aw = 1'b1; n_pend = i_item.opcode;
                        end else if (y[2:1] == 2'd2) begin
                            n_pc = r_hl; n_r0.cycle_count = 5'd4;
                        end else begin
                            n_sp = r_hl; n_pc = r_pc + 16'd1; n_r0.cycle_count = 5'd8;
                        end
                    end
                    3'd2: begin
                        if (!y[2]) begin
                            if (cond) begin
                                n_pc = i_item.immediate; n_r0.cycle_count = 5'd16;
                            end else begin
                                n_pc = r_pc + 16'd3; n_r0.cycle_count = 5'd12;
                            end
                        end else if (y == 3'd4 || y == 3'd5) begin
                            n_r1 = n_r0; n_cnt = 2'd2;
                            if (y == 3'd4) begin
                                n_r0 = mk(KIND_WRITE, HIGH_PAGE + {8'd0, r_bc[7:0]},
                                          {8'd0, r_a}, 1'b0, 1'b0);
                                n_pc = r_pc + 16'd1; n_r1.cycle_count = 5'd8;
                            end else begin
                                n_r0 = mk(KIND_WRITE, i_item.immediate, {8'd0, r_a},
                                          1'b0, 1'b0);
                                n_pc = r_pc + 16'd3; n_r1.cycle_count = 5'd16;
                            end
                        end else begin
                            n_r0 = mk(KIND_READ, (y == 3'd6) ?
                                      HIGH_PAGE + {8'd0, r_bc[7:0]} : i_item.immediate,
                                      16'd0, 1'b0, 1'b1);
                            n_aw = 1'b1; n_pend = i_item.opcode;
                        end
                    end
                    3'd3: begin
                        if (y == 3'd0) begin
                            n_pc = i_item.immediate; n_r0.cycle_count = 5'd16;
                        end else if (y == 3'd1) begin
                            n_r0.status = ST_PREFIX;
                        end else if (y[2:1] == 2'd3) begin
                            n_ime = y[0]; n_pc = r_pc + 16'd1; n_r0.cycle_count = 5'd4;
                        end else begin
                            n_r0.status = ST_ILLEGAL;
                        end
                    end
                    3'd4, 3'd5: begin
                        if ((z == 3'd4 && y[2]) || (z == 3'd5 && y[0] && y[2:1] != 2'd0))
                        begin
                            n_r0.status = ST_ILLEGAL;
                        end else if (z == 3'd4 && !cond) begin
                            n_pc = r_pc + 16'd3; n_r0.cycle_count = 5'd12;
                        end else begin
                            n_r1 = n_r0; n_cnt = 2'd2; n_sp = pushsp;
                            if (z == 3'd5 && !y[0]) begin
                                case (y[2:1])
                                    2'd0: n_r0 = mk(KIND_WRITE, pushsp, r_bc, 1'b1, 1'b0);
                                    2'd1: n_r0 = mk(KIND_WRITE, pushsp, r_de, 1'b1, 1'b0);
                                    2'd2: n_r0 = mk(KIND_WRITE, pushsp, r_hl, 1'b1, 1'b0);
                                    default: n_r0 = mk(KIND_WRITE, pushsp,
                                                       {r_a, r_f, 4'd0}, 1'b1, 1'b0);
                                endcase
                                n_pc = r_pc + 16'd1; n_r1.cycle_count = 5'd16;
                            end else begin
                                n_r0 = mk(KIND_WRITE, pushsp, r_pc + 16'd3, 1'b1, 1'b0);
                                n_pc = i_item.immediate; n_r1.cycle_count = 5'd24;
                            end
                        end
                    end
                    3'd6: begin
                        case (y)
                            3'd0, 3'd1: begin
                                sum = {1'b0, r_a} + {1'b0, b} + {8'd0, y[0] & r_f[0]};
                                hs = {1'b0, r_a[3:0]} + {1'b0, b[3:0]} +
                                     {4'd0, y[0] & r_f[0]};
                                if (hs[4]) fl = fl | FL_H;
                                if (sum[8]) fl = fl | FL_C;
                            end
                            3'd2, 3'd3, 3'd7: begin
                                sum = {1'b0, r_a} - {1'b0, b} - {8'd0, y == 3'd3 & r_f[0]};
                                hs = {1'b0, r_a[3:0]} - {1'b0, b[3:0]} -
                                     {4'd0, y == 3'd3 & r_f[0]};
                                fl = FL_N;
                                if (hs[4]) fl = fl | FL_H;
                                if (sum[8]) fl = fl | FL_C;
                            end
                            3'd4: begin sum = {1'b0, r_a & b}; fl = FL_H; end
                            3'd5: sum = {1'b0, r_a ^ b};
                            default: sum = {1'b0, r_a | b};
                        endcase
                        if (sum[7:0] == 8'd0) fl = fl | FL_Z;
                        n_f = fl;
                        if (y != 3'd7) n_a = sum[7:0];
                        n_pc = r_pc + 16'd2; n_r0.cycle_count = 5'd8;
                    end
                    default: begin
                        n_r1 = n_r0; n_cnt = 2'd2; n_sp = pushsp;
                        n_r0 = mk(KIND_WRITE, pushsp, r_pc + 16'd1, 1'b1, 1'b0);
                        n_pc = {10'd0, y, 3'd0}; n_r1.cycle_count = 5'd16;
                    end
                endcase
            end
        end else if (r_aw) begin
            n_aw = 1'b0; n_cnt = 2'd1;
            n_r0 = mk(KIND_DONE, 16'd0, 16'd0, 1'b0, 1'b1);
            n_r0.status = ST_OK;
            if (pz == 3'd0 && !py[2]) begin
                n_pc = d; n_sp = r_sp + 16'd2; n_r0.cycle_count = 5'd20;
            end else if (pz == 3'd0) begin
                n_a = d[7:0]; n_pc = r_pc + 16'd2; n_r0.cycle_count = 5'd12;
            end else if (pz == 3'd1 && !py[0]) begin
                case (py[2:1])
                    2'd0: n_bc = d;
                    2'd1: n_de = d;
                    2'd2: n_hl = d;
                    default: begin n_a = d[15:8]; n_f = d[7:4]; end
                endcase
                n_sp = r_sp + 16'd2; n_pc = r_pc + 16'd1; n_r0.cycle_count = 5'd12;
            end else if (pz == 3'd1) begin
                n_pc = d; n_sp = r_sp + 16'd2; n_r0.cycle_count = 5'd16;
                if (py == 3'd3) n_ime = 1'b1;
            end else begin
                n_a = d[7:0];
                n_pc = r_pc + (py == 3'd6 ? 16'd1 : 16'd3);
                n_r0.cycle_count = (py == 3'd6) ? 5'd8 : 5'd16;
            end
        end
        n_r0.next_pc = n_pc; n_r0.acc_value = n_a; n_r0.flags_znhc = n_f;
        n_r1.next_pc = n_pc; n_r1.acc_value = n_a; n_r1.flags_znhc = n_f;
        if (n_r0.kind != KIND_DONE) begin
            n_r0.next_pc = '0; n_r0.acc_value = '0; n_r0.flags_znhc = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a <= '0; r_f <= '0; r_bc <= '0; r_de <= '0; r_hl <= '0; r_sp <= '0;
            r_pc <= '0; r_ime <= 1'b0; r_aw <= 1'b0; r_pend <= '0;
            r_v0 <= 1'b0; r_v1 <= 1'b0;
        end else begin
            if (go) begin
                r_a <= n_a; r_f <= n_f; r_bc <= n_bc; r_de <= n_de; r_hl <= n_hl;
                r_sp <= n_sp; r_pc <= n_pc; r_ime <= n_ime; r_aw <= n_aw;
                r_pend <= n_pend;
                r_v0 <= (n_cnt != 2'd0); r_v1 <= (n_cnt == 2'd2);
                r_out0 <= n_r0; r_out1 <= n_r1;
            end else if (r_v0 && !i_stall) begin
                r_v0 <= r_v1; r_v1 <= 1'b0; r_out0 <= r_out1;
            end
        end
    end
endmodule

// ===== rtl/cpu_control_stack_alu_imm_exec.sv =====
// Top level of the SM83 quadrant-3 opcode execute block.
// Input channel: execute words (cmd 0) carry an opcode and its immediate bytes;
// response words (cmd 1) return data for the last read request.
// Output channel: bus read and write requests and one done word per
// instruction, the final word of each input marked by o_last.
// A two-entry queue in front decouples acceptance from execution; the back
// stage executes one word per cycle when its output register is free.
// An accepted input word is held in the queue, then registered in the output register.
// Words with a single result are taken one per cycle while i_stall is low; a word that
// causes a write and a done blocks the next word until the write has been taken.
// Reset clears all CPU registers and empties the queue and the output register.
// A stalled receiver holds the current result; the queue fills, then
// i_stall-style backpressure reaches the sender through o_stall.
`timescale 1ns / 1ps
module cpu_control_stack_alu_imm_exec (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_cmd,
    input  logic [7:0]  i_opcode,
    input  logic [15:0] i_immediate,
    input  logic [15:0] i_read_data,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_kind,
    output logic [15:0] o_bus_address,
    output logic [15:0] o_write_data,
    output logic        o_word_access,
    output logic [1:0]  o_status,
    output logic [4:0]  o_cycle_count,
    output logic [15:0] o_next_pc,
    output logic [7:0]  o_acc_value,
    output logic [3:0]  o_flags_znhc,
    output logic        o_last
);
    import ccs_pkg::*;
    t_item   in_item, q_item;
    t_result res;
    logic    q_valid, q_take;

    assign in_item = '{cmd: i_cmd, opcode: i_opcode, immediate: i_immediate,
                       read_data: i_read_data};

    ccs_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_item(in_item), .o_valid(q_valid), .i_take(q_take), .o_item(q_item)
    );

    ccs_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(q_valid), .o_take(q_take),
        .i_item(q_item), .o_valid(o_valid), .i_stall(i_stall), .o_res(res)
    );

    assign o_kind        = res.kind;
    assign o_bus_address = res.bus_address;
    assign o_write_data  = res.write_data;
    assign o_word_access = res.word_access;
    assign o_status      = res.status;
    assign o_cycle_count = res.cycle_count;
    assign o_next_pc     = res.next_pc;
    assign o_acc_value   = res.acc_value;
    assign o_flags_znhc  = res.flags_znhc;
    assign o_last        = res.last;

    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind == KIND_DONE |-> o_last) else $error("done without last");
    a_req_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind != KIND_DONE |-> o_cycle_count == 5'd0 && o_status == ST_OK)
        else $error("request carries done fields");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_kind) && $stable(o_bus_address))
        else $error("stalled result changed");
endmodule

// ===== dv/tb_cpu_control_stack_alu_imm_exec.sv =====
// Testbench for the quadrant-3 opcode execute block, checked against a predictor.
`timescale 1ns / 1ps
module tb_cpu_control_stack_alu_imm_exec;
    import ccs_pkg::*;

    class exec_scoreboard;
        logic [7:0]  acc;
        logic [3:0]  fl;
        logic [15:0] bc, de, hl, sp, pc;
        logic        ime;
        logic [7:0]  pend_op;
        logic        awaiting;
        t_result     expected_q[$];
        int          errors;

        function new();
            acc = 0; fl = 0; bc = 0; de = 0; hl = 0; sp = 0; pc = 0; ime = 0;
            pend_op = 0; awaiting = 0; errors = 0;
        endfunction

        function void emit(logic [1:0] k, logic [15:0] a, logic [15:0] d, logic w,
                           logic [1:0] st, logic [4:0] cyc, logic lst);
            t_result r;
            r.kind = k; r.bus_address = a; r.write_data = d; r.word_access = w;
            r.status = st; r.cycle_count = cyc; r.last = lst;
            r.next_pc = (k == KIND_DONE) ? pc : 16'h0;
            r.acc_value = (k == KIND_DONE) ? acc : 8'h0;
            r.flags_znhc = (k == KIND_DONE) ? fl : 4'h0;
            expected_q.push_back(r);
        endfunction

        function void finish(logic [1:0] st, logic [4:0] cyc);
            emit(KIND_DONE, 0, 0, 0, st, cyc, 1);
        endfunction

        function void request_read(logic [7:0] op, logic [15:0] a, logic w);
            pend_op = op; awaiting = 1;
            emit(KIND_READ, a, 0, w, ST_OK, 0, 1);
        endfunction

        function void push_word(logic [15:0] v);
            sp = sp - 16'd2;
            emit(KIND_WRITE, sp, v, 1, ST_OK, 0, 0);
        endfunction

        function logic cond_met(logic [1:0] c);
            case (c)
                2'd0: return !fl[3];
                2'd1: return fl[3];
                2'd2: return !fl[0];
                default: return fl[0];
            endcase
        endfunction

        function logic [15:0] sp_plus(logic [7:0] b);
            logic [3:0] f;
            f = 0;
            if ({1'b0, sp[3:0]} + {1'b0, b[3:0]} > 5'hF) f |= FL_H;
            if ({1'b0, sp[7:0]} + {1'b0, b} > 9'hFF) f |= FL_C;
            fl = f;
            return sp + {{8{b[7]}}, b};
        endfunction

        function void alu_op(logic [2:0] y, logic [7:0] v);
            logic [8:0] r;
            logic [3:0] f;
            logic       c;
            c = fl[0]; f = 0;
            case (y)
                3'd0: begin
                    r = acc + v;
                    if (acc[3:0] + v[3:0] > 5'hF) f |= FL_H;
                    if (r[8]) f |= FL_C;
                end
                3'd1: begin
                    r = acc + v + c;
                    if (acc[3:0] + v[3:0] + c > 5'hF) f |= FL_H;
                    if (r[8]) f |= FL_C;
                end
                3'd2, 3'd7: begin
                    r = acc - v; f |= FL_N;
                    if (acc[3:0] < v[3:0]) f |= FL_H;
                    if (acc < v) f |= FL_C;
                end
                3'd3: begin
                    r = acc - v - c; f |= FL_N;
                    if ({1'b0, acc[3:0]} < {1'b0, v[3:0]} + c) f |= FL_H;
                    if ({1'b0, acc} < {1'b0, v} + c) f |= FL_C;
                end
                3'd4: begin r = acc & v; f |= FL_H; end
                3'd5: r = acc ^ v;
                default: r = acc | v;
            endcase
            if (r[7:0] == 0) f |= FL_Z;
            fl = f;
            if (y != 3'd7) acc = r[7:0];
        endfunction

        function void execute(logic [7:0] op, logic [15:0] imm);
            logic [2:0] y, z;
            logic [1:0] p;
            logic       q;
            logic [7:0] b;
            y = op[5:3]; z = op[2:0]; p = y[2:1]; q = y[0]; b = imm[7:0];
            if (op < 8'hC0) begin finish(ST_ILLEGAL, 0); return; end
            case (z)
                3'd0: begin
                    if (y < 4) begin
                        if (cond_met(y[1:0])) request_read(op, sp, 1);
                        else begin pc = pc + 1; finish(ST_OK, 8); end
                    end else if (y == 4) begin
                        emit(KIND_WRITE, HIGH_PAGE + b, {8'h0, acc}, 0, ST_OK, 0, 0);
                        pc = pc + 2; finish(ST_OK, 12);
                    end else if (y == 6) request_read(op, HIGH_PAGE + b, 0);
                    else begin
                        if (y == 5) sp = sp_plus(b); else hl = sp_plus(b);
                        pc = pc + 2; finish(ST_OK, y == 5 ? 5'd16 : 5'd12);
                    end
                end
                3'd1: begin
                    if (!q || p < 2) request_read(op, sp, 1);
                    else if (p == 2) begin pc = hl; finish(ST_OK, 4); end
                    else begin sp = hl; pc = pc + 1; finish(ST_OK, 8); end
                end
                3'd2: begin
                    if (y < 4) begin
                        if (cond_met(y[1:0])) begin pc = imm; finish(ST_OK, 16); end
                        else begin pc = pc + 3; finish(ST_OK, 12); end
                    end else if (y == 4) begin
                        emit(KIND_WRITE, HIGH_PAGE + bc[7:0], {8'h0, acc}, 0, ST_OK, 0, 0);
                        pc = pc + 1; finish(ST_OK, 8);
                    end else if (y == 5) begin
                        emit(KIND_WRITE, imm, {8'h0, acc}, 0, ST_OK, 0, 0);
                        pc = pc + 3; finish(ST_OK, 16);
                    end else if (y == 6) request_read(op, HIGH_PAGE + bc[7:0], 0);
                    else request_read(op, imm, 0);
                end
                3'd3: begin
                    if (y == 0) begin pc = imm; finish(ST_OK, 16); end
                    else if (y == 1) finish(ST_PREFIX, 0);
                    else if (y >= 6) begin ime = (y == 7); pc = pc + 1; finish(ST_OK, 4); end
                    else finish(ST_ILLEGAL, 0);
                end
                3'd4: begin
                    if (y > 3) finish(ST_ILLEGAL, 0);
                    else if (!cond_met(y[1:0])) begin pc = pc + 3; finish(ST_OK, 12); end
                    else begin push_word(pc + 3); pc = imm; finish(ST_OK, 24); end
                end
                3'd5: begin
                    if (!q) begin
                        case (p)
                            2'd0: push_word(bc);
                            2'd1: push_word(de);
                            2'd2: push_word(hl);
                            default: push_word({acc, fl, 4'h0});
                        endcase
                        pc = pc + 1; finish(ST_OK, 16);
                    end else if (p != 0) finish(ST_ILLEGAL, 0);
                    else begin push_word(pc + 3); pc = imm; finish(ST_OK, 24); end
                end
                3'd6: begin alu_op(y, b); pc = pc + 2; finish(ST_OK, 8); end
                default: begin push_word(pc + 1); pc = {10'h0, y, 3'h0}; finish(ST_OK, 16); end
            endcase
        endfunction

        function void respond(logic [15:0] d);
            logic [2:0] y, z;
            y = pend_op[5:3]; z = pend_op[2:0];
            awaiting = 0;
            if (z == 0 && y < 4) begin
                pc = d; sp = sp + 2; finish(ST_OK, 20);
            end else if (z == 0 && y == 6) begin
                acc = d[7:0]; pc = pc + 2; finish(ST_OK, 12);
            end else if (z == 1 && !y[0]) begin
                case (y[2:1])
                    2'd0: bc = d;
                    2'd1: de = d;
                    2'd2: hl = d;
                    default: begin acc = d[15:8]; fl = d[7:4]; end
                endcase
                sp = sp + 2; pc = pc + 1; finish(ST_OK, 12);
            end else if (z == 1) begin
                pc = d; sp = sp + 2;
                if (y == 3) ime = 1;
                finish(ST_OK, 16);
            end else if (z == 2 && y >= 6) begin
                acc = d[7:0];
                pc = pc + (y == 6 ? 16'd1 : 16'd3);
                finish(ST_OK, y == 6 ? 5'd8 : 5'd16);
            end
        endfunction

        function void note_input(t_item it);
            if (it.cmd == CMD_EXEC) begin
                awaiting = 0;
                execute(it.opcode, it.immediate);
            end else if (awaiting) respond(it.read_data);
        endfunction

        function void check_result(t_result got);
            t_result e;
            if (expected_q.size() == 0) begin
                $error("unexpected result word kind=%0d", got.kind);
                errors++;
                return;
            end
            e = expected_q.pop_front();
            if (got.kind !== e.kind) begin
                $error("kind exp %0h got %0h", e.kind, got.kind); errors++; end
            if (got.bus_address !== e.bus_address) begin
                $error("bus_address exp %0h got %0h", e.bus_address, got.bus_address);
                errors++; end
            if (got.write_data !== e.write_data) begin
                $error("write_data exp %0h got %0h", e.write_data, got.write_data);
                errors++; end
            if (got.word_access !== e.word_access) begin
                $error("word_access exp %0h got %0h", e.word_access, got.word_access);
                errors++; end
            if (got.status !== e.status) begin
                $error("status exp %0h got %0h", e.status, got.status); errors++; end
            if (got.cycle_count !== e.cycle_count) begin
                $error("cycle_count exp %0d got %0d", e.cycle_count, got.cycle_count);
                errors++; end
            if (got.next_pc !== e.next_pc) begin
                $error("next_pc exp %0h got %0h", e.next_pc, got.next_pc); errors++; end
            if (got.acc_value !== e.acc_value) begin
                $error("acc_value exp %0h got %0h", e.acc_value, got.acc_value); errors++; end
            if (got.flags_znhc !== e.flags_znhc) begin
                $error("flags_znhc exp %0h got %0h", e.flags_znhc, got.flags_znhc);
                errors++; end
            if (got.last !== e.last) begin
                $error("last exp %0h got %0h", e.last, got.last); errors++; end
        endfunction
    endclass

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_valid = 0;
    logic        o_stall;
    logic        i_cmd = 0;
    logic [7:0]  i_opcode = 0;
    logic [15:0] i_immediate = 0;
    logic [15:0] i_read_data = 0;
    logic        o_valid;
    logic        i_stall = 0;
    logic [1:0]  o_kind;
    logic [15:0] o_bus_address;
    logic [15:0] o_write_data;
    logic        o_word_access;
    logic [1:0]  o_status;
    logic [4:0]  o_cycle_count;
    logic [15:0] o_next_pc;
    logic [7:0]  o_acc_value;
    logic [3:0]  o_flags_znhc;
    logic        o_last;

    exec_scoreboard sb = new();
    bit quiet_window = 0;

    cpu_control_stack_alu_imm_exec DUT (.*);

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        t_result r;
        if (i_rst_n && o_valid && !i_stall) begin
            r.kind = o_kind; r.bus_address = o_bus_address; r.write_data = o_write_data;
            r.word_access = o_word_access; r.status = o_status;
            r.cycle_count = o_cycle_count; r.next_pc = o_next_pc;
            r.acc_value = o_acc_value; r.flags_znhc = o_flags_znhc; r.last = o_last;
            sb.check_result(r);
        end
    end

    always @(negedge i_clk) begin
        i_stall <= (!quiet_window && $urandom_range(99) < 9);
    end

    task automatic send_word(t_item it);
        while (!quiet_window && $urandom_range(99) < 9) begin
            i_valid <= 0;
            @(negedge i_clk);
        end
        i_valid <= 1; i_cmd <= it.cmd; i_opcode <= it.opcode;
        i_immediate <= it.immediate; i_read_data <= it.read_data;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sb.note_input(it);
        @(negedge i_clk);
    endtask

    task automatic send_exec(logic [7:0] op, logic [15:0] imm);
        t_item it;
        it.cmd = CMD_EXEC; it.opcode = op; it.immediate = imm; it.read_data = 16'($urandom);
        send_word(it);
    endtask

    task automatic send_resp(logic [15:0] d);
        t_item it;
        it.cmd = CMD_RESP; it.opcode = 8'($urandom); it.immediate = 16'($urandom);
        it.read_data = d;
        send_word(it);
    endtask

    initial begin
        int n;
        logic [7:0] op;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1;
        // directed: extremes, special cases
        send_exec(8'h00, 16'hFFFF);
        send_exec(8'hCB, 16'h0000);
        send_exec(8'hD3, 16'h1234);
        send_resp(16'hABCD);
        send_exec(8'hC6, 16'h00FF);
        send_exec(8'hCE, 16'h0001);
        send_exec(8'hD6, 16'h0080);
        send_exec(8'hDE, 16'h00FF);
        send_exec(8'hE6, 16'h000F);
        send_exec(8'hEE, 16'hFFAA);
        send_exec(8'hF6, 16'h0000);
        send_exec(8'hFE, 16'h0001);
        send_exec(8'hF0, 16'h0042);
        send_resp(16'hFF7E);
        send_exec(8'hC1, 16'h0);
        send_exec(8'hC5, 16'h0);
        send_resp(16'hFFFF);
        send_exec(8'hE8, 16'h0080);
        send_exec(8'hF8, 16'h007F);
        send_exec(8'hFB, 16'h0);
        send_exec(8'hF3, 16'h0);
        send_exec(8'hCD, 16'hFFFF);
        send_exec(8'hD9, 16'h0);
        send_resp(16'h0000);
        send_exec(8'hFF, 16'h0);
        for (n = 0; n < 1100; n++) begin
            quiet_window = (n >= 500 && n < 700);
            if ($urandom_range(9) == 0) op = 8'($urandom);
            else op = 8'hC0 | 8'($urandom_range(63));
            send_exec(op, 16'($urandom));
            if (sb.awaiting && $urandom_range(9) != 0) send_resp(16'($urandom));
            else if ($urandom_range(19) == 0) send_resp(16'($urandom));
        end
        i_valid <= 0;
        quiet_window = 0;
        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (sb.errors == 0 && sb.expected_q.size() == 0) $display("RESULT: OK");
        else $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        #2000000;
        $display("RESULT: ERROR");
        $finish;
    end
endmodule
